/* rtl/core/ook_pkg.sv */
package ook_pkg;

    localparam int ITEM_W = 80;
    localparam int RES_W  = 16;
    localparam int CFG_W  = 19;
    localparam int NUM_W  = 29;
    localparam int REM_W  = 20;
    localparam int CNT_W  = 5;

    localparam logic [3:0] CMD_TICK    = 4'd0;
    localparam logic [3:0] CMD_INIT    = 4'd1;
    localparam logic [3:0] CMD_DEINIT  = 4'd2;
    localparam logic [3:0] CMD_RX_CONT = 4'd3;
    localparam logic [3:0] CMD_RX_SGL  = 4'd4;
    localparam logic [3:0] CMD_SEND    = 4'd5;
    localparam logic [3:0] CMD_STANDBY = 4'd6;
    localparam logic [3:0] CMD_SLEEP   = 4'd7;
    localparam logic [3:0] CMD_PIN     = 4'd8;
    localparam logic [3:0] CMD_TAKE    = 4'd9;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_WRONG = 3'd1;
    localparam logic [2:0] ST_BUSY  = 3'd2;
    localparam logic [2:0] ST_INVAL = 3'd3;
    localparam logic [2:0] ST_HWERR = 3'd4;

    localparam logic [2:0] MODE_UNINIT = 3'd0;
    localparam logic [2:0] MODE_STBY   = 3'd1;
    localparam logic [2:0] MODE_RXC    = 3'd2;
    localparam logic [2:0] MODE_RXS    = 3'd3;
    localparam logic [2:0] MODE_TX     = 3'd4;

    localparam logic [4:0] EV_RXD = 5'b00001;
    localparam logic [4:0] EV_TXD = 5'b00010;
    localparam logic [4:0] EV_RXT = 5'b00100;
    localparam logic [4:0] EV_OVR = 5'b01000;
    localparam logic [4:0] EV_HWE = 5'b10000;

    localparam logic [1:0] REG_BIT_RATE = 2'd0;
    localparam logic [1:0] REG_PREAMBLE = 2'd1;
    localparam logic [1:0] REG_SYNC     = 2'd2;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic commit;
    } ook_ctrl_t;

    typedef struct packed {
        logic needs_div;
        logic div_last;
        logic out_free;
    } ook_stat_t;

endpackage

/* rtl/core/ook_ctrl.sv */
module ook_ctrl import ook_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ook_stat_t stat,
    output ook_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctrl = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                ctrl.load = 1'b1;
                state_next = stat.needs_div ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                ctrl.step = 1'b1;
                if (stat.div_last) state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    ctrl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

endmodule

/* rtl/core/ook_dp.sv */
module ook_dp import ook_pkg::*; #(
    parameter int MAX_PAYLOAD = 63,
    parameter int FIFO_BYTES  = 64,
    parameter int TX_GUARD_MS = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic [ITEM_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RES_W-1:0]  m_tdata,
    input  ook_ctrl_t         ctrl,
    output ook_stat_t         stat
);

    logic [18:0] bit_rate_reg;
    logic [15:0] preamble_reg;
    logic [2:0]  sync_reg;

    logic [2:0]  mode_reg, resume_reg;
    logic [31:0] rx_dl_reg, tx_dl_reg;
    logic        pin_reg;
    logic [4:0]  evst_reg;

    logic [ITEM_W-1:0] item_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_tvalid_reg;
    logic [RES_W-1:0]  m_tdata_reg;

    logic [3:0]  cmd;
    logic [31:0] now;
    logic [15:0] sym;
    logic [7:0]  len;
    logic        dio0, f_to, f_rdy, f_sent, f_ovr, hw;
    logic [7:0]  rx_len;

    assign cmd    = item_reg[3:0];
    assign now    = item_reg[35:4];
    assign sym    = item_reg[51:36];
    assign len    = item_reg[59:52];
    assign dio0   = item_reg[60];
    assign f_to   = item_reg[61];
    assign f_rdy  = item_reg[62];
    assign f_sent = item_reg[63];
    assign f_ovr  = item_reg[64];
    assign rx_len = item_reg[72:65];
    assign hw     = item_reg[73];

    logic [18:0]      dvs;
    logic [REM_W-1:0] trial;
    logic             fits;
    logic [16:0]      total;
    logic [NUM_W-1:0] num_rx, num_tx;
    logic [31:0]      q_ceil, rx_dl_val, tx_dl_val;
    logic [31:0]      rx_age, tx_age;
    logic             inited, len_bad, rxs_ok, send_ok, resumed_rx;
    logic [2:0]       resumed;

    assign dvs   = (bit_rate_reg == 19'd0) ? 19'd1 : bit_rate_reg;
    assign trial = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, dvs};
    assign total = 17'(preamble_reg) + 17'(sync_reg) + 17'(len) + 17'd3;
    assign num_rx = NUM_W'({13'd0, sym} * 29'd1000);
    assign num_tx = NUM_W'({12'd0, total} * 29'd8000);
    assign q_ceil = 32'(quo_reg) + 32'(rem_reg != '0);
    assign rx_dl_val = now + q_ceil + 32'd2;
    assign tx_dl_val = now + q_ceil + 32'(TX_GUARD_MS);
    assign rx_age = now - rx_dl_reg;
    assign tx_age = now - tx_dl_reg;

    assign inited  = mode_reg != MODE_UNINIT;
    assign len_bad = (len == 8'd0) || (32'(len) > 32'(MAX_PAYLOAD))
                   || (32'(len) + 32'd1 > 32'(FIFO_BYTES));
    assign rxs_ok  = inited && mode_reg != MODE_TX && sym != 16'd0 && hw;
    assign send_ok = inited && !len_bad && mode_reg != MODE_TX && hw;
    assign resumed_rx = (resume_reg == MODE_RXC) || (resume_reg == MODE_RXS);
    assign resumed = resumed_rx ? resume_reg : MODE_STBY;

    assign stat.needs_div = ((cmd == CMD_RX_SGL) && rxs_ok) || ((cmd == CMD_SEND) && send_ok);
    assign stat.div_last  = cnt_reg == '0;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    logic [2:0]  mode_n, resume_n, st;
    logic [31:0] rx_dl_n, tx_dl_n;
    logic        pin_n, pend, stop;
    logic [4:0]  evst_n, ev, taken;

    always_comb begin
        mode_n = mode_reg;
        resume_n = resume_reg;
        rx_dl_n = rx_dl_reg;
        tx_dl_n = tx_dl_reg;
        pin_n = pin_reg;
        evst_n = evst_reg;
        st = ST_OK;
        ev = '0;
        taken = '0;
        pend = pin_reg || dio0;
        stop = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (inited) begin
                    pin_n = 1'b0;
                    if (!pend && mode_reg != MODE_TX) begin
                        if (mode_reg == MODE_RXS && !rx_age[31]) begin
                            ev = ev | EV_RXT;
                            if (hw) mode_n = MODE_STBY;
                        end else begin
                            stop = 1'b1;
                        end
                    end
                    if (!stop) begin
                        if (!pend && mode_n == MODE_TX && !tx_age[31]) begin
                            mode_n = resumed;
                            ev = ev | EV_HWE;
                        end else if (!hw) begin
                            ev = ev | EV_HWE;
                        end else begin
                            if (f_ovr) ev = ev | EV_OVR;
                            if (f_to) begin
                                ev = ev | EV_RXT;
                                if (mode_n == MODE_RXS) mode_n = MODE_STBY;
                            end
                            if (f_rdy) begin
                                ev = ev | ((32'(rx_len) > 32'(MAX_PAYLOAD)) ? EV_OVR : EV_RXD);
                                if (mode_n == MODE_RXS) mode_n = MODE_STBY;
                            end
                            if (f_sent) begin
                                ev = ev | EV_TXD;
                                mode_n = resumed;
                                tx_dl_n = '0;
                            end
                        end
                    end
                    evst_n = evst_reg | ev;
                end
            end
            CMD_INIT: begin
                if (bit_rate_reg < 19'd600 || bit_rate_reg > 19'd300000
                    || preamble_reg == 16'd0 || sync_reg > 3'd4) begin
                    st = ST_INVAL;
                end else begin
                    mode_n = hw ? MODE_STBY : MODE_UNINIT;
                    resume_n = MODE_UNINIT;
                    rx_dl_n = '0;
                    tx_dl_n = '0;
                    pin_n = 1'b0;
                    evst_n = '0;
                    if (!hw) st = ST_HWERR;
                end
            end
            CMD_DEINIT: begin
                if (!inited) begin
                    st = ST_WRONG;
                end else begin
                    mode_n = MODE_UNINIT;
                    resume_n = MODE_UNINIT;
                    rx_dl_n = '0;
                    tx_dl_n = '0;
                    pin_n = 1'b0;
                    evst_n = '0;
                end
            end
            CMD_RX_CONT, CMD_RX_SGL: begin
                if (!inited) st = ST_WRONG;
                else if (mode_reg == MODE_TX) st = ST_BUSY;
                else if (cmd == CMD_RX_SGL && sym == 16'd0) st = ST_INVAL;
                else if (!hw) st = ST_HWERR;
                else if (cmd == CMD_RX_CONT) mode_n = MODE_RXC;
                else begin
                    rx_dl_n = rx_dl_val;
                    mode_n = MODE_RXS;
                end
            end
            CMD_SEND: begin
                if (!inited) st = ST_WRONG;
                else if (len_bad) st = ST_INVAL;
                else if (mode_reg == MODE_TX) st = ST_BUSY;
                else begin
                    resume_n = mode_reg;
                    if (!hw) begin
                        st = ST_HWERR;
                    end else begin
                        pin_n = 1'b0;
                        mode_n = MODE_TX;
                        tx_dl_n = tx_dl_val;
                    end
                end
            end
            CMD_STANDBY, CMD_SLEEP: begin
                if (!inited) st = ST_WRONG;
                else if (!hw) st = ST_HWERR;
                else mode_n = MODE_STBY;
            end
            CMD_PIN: begin
                if (inited) pin_n = 1'b1;
            end
            CMD_TAKE: begin
                taken = evst_reg;
                evst_n = '0;
            end
            default: st = ST_INVAL;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_rate_reg <= 19'd4800;
            preamble_reg <= 16'd8;
            sync_reg <= 3'd2;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BIT_RATE: bit_rate_reg <= cfg_wr_data;
                REG_PREAMBLE: preamble_reg <= cfg_wr_data[15:0];
                REG_SYNC:     sync_reg <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UNINIT;
            resume_reg <= MODE_UNINIT;
            rx_dl_reg <= '0;
            tx_dl_reg <= '0;
            pin_reg <= 1'b0;
            evst_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctrl.commit) begin
                mode_reg <= mode_n;
                resume_reg <= resume_n;
                rx_dl_reg <= rx_dl_n;
                tx_dl_reg <= tx_dl_n;
                pin_reg <= pin_n;
                evst_reg <= evst_n;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) item_reg <= s_tdata;
        if (ctrl.load) begin
            quo_reg <= (cmd == CMD_RX_SGL) ? num_rx : num_tx;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(NUM_W - 1);
        end else if (ctrl.step) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial - {1'b0, dvs} : trial;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (ctrl.commit) m_tdata_reg <= {taken, ev[4], ev[3], ev[2], ev[1], ev[0], mode_n, st};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/core/ook_radio_mode_controller_unit.sv */
// Each accepted word passes through the load and commit states, and for rx single and
// send commands that set a deadline also through a 29-step restoring divider by bit rate.
// A new word is taken only after the last result is committed; a result
// held back by m_tready stalls the next word.
// Reset: synchronous active-low aresetn restores mode uninit, clears
// deadlines and events, and loads registers 4800 / 8 / 2.
module ook_radio_mode_controller_unit import ook_pkg::*; #(
    parameter int MAX_PAYLOAD = 63,
    parameter int FIFO_BYTES  = 64,
    parameter int TX_GUARD_MS = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // cmd, now_ms, rx symbol count, tx byte count, dio0_level, irq_timeout,
    // irq_payload_ready, irq_packet_sent, irq_fifo_overrun, rx_packet_len, hw_ok
    input  logic [ITEM_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status, mode, ev_rx_done, ev_tx_done, ev_rx_timeout, ev_fifo_overrun,
    // ev_hw_error, taken_events
    output logic [RES_W-1:0]  m_tdata
);

    ook_ctrl_t ctrl;
    ook_stat_t stat;

    ook_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ook_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .FIFO_BYTES  (FIFO_BYTES),
        .TX_GUARD_MS (TX_GUARD_MS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .ctrl        (ctrl),
        .stat        (stat)
    );

endmodule
